/* rtl/core/scha_pkg.sv */
// Shared constants and types for the split/coalesce heap allocator.
// No dependencies.
package scha_pkg;

  localparam int BUFFER_BYTES = 16384;
  localparam int HEADER_BYTES = 20;
  localparam int MAX_REQUEST  = 65535;
  localparam int HEAP_SLOTS   = 4096;

  // offset/length width, slot index width, count width
  localparam int AW = $clog2(BUFFER_BYTES);
  localparam int IW = $clog2(HEAP_SLOTS);
  localparam int CW = IW + 1;
  // rounded request width, and common width for compares and sums
  localparam int SW = 17;
  localparam int KW = ((AW > SW) ? AW : SW) + 1;

  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_AFAIL = 2'd1;
  localparam logic [1:0] ST_FBAD  = 2'd2;

  typedef struct packed {
    logic          used;
    logic [AW-1:0] len;
    logic [AW-1:0] start;
  } hdr_t;

  localparam int HW = $bits(hdr_t);

  typedef struct packed {
    logic          re;
    logic [IW-1:0] raddr;
    logic          we;
    logic [IW-1:0] waddr;
    hdr_t          wdata;
  } mem_req_t;

  typedef struct packed {
    logic        valid;
    logic [13:0] addr;
    logic [1:0]  status;
  } res_t;

endpackage

/* rtl/core/scha_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module scha_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/core/scha_ctrl.sv */
// Sequencer that walks, splits and merges the header chain in the header RAM.
// Depends on scha_pkg.
module scha_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic              action,
  input  logic [15:0]       req_size,
  input  logic [13:0]       block_addr,
  input  scha_pkg::hdr_t    rdata,
  output scha_pkg::mem_req_t mem,
  output scha_pkg::res_t    fin,
  output logic              idle
);
  import scha_pkg::*;

  localparam logic [4:0] S_INIT  = 5'd0;
  localparam logic [4:0] S_IDLE  = 5'd1;
  localparam logic [4:0] S_ARD   = 5'd2;
  localparam logic [4:0] S_ACK   = 5'd3;
  localparam logic [4:0] S_UPRD  = 5'd4;
  localparam logic [4:0] S_UPWR  = 5'd5;
  localparam logic [4:0] S_UPNEW = 5'd6;
  localparam logic [4:0] S_FRD   = 5'd7;
  localparam logic [4:0] S_FCK   = 5'd8;
  localparam logic [4:0] S_NRD   = 5'd9;
  localparam logic [4:0] S_NCK   = 5'd10;
  localparam logic [4:0] S_PRE   = 5'd11;
  localparam logic [4:0] S_PCK   = 5'd12;
  localparam logic [4:0] S_DEL   = 5'd13;
  localparam logic [4:0] S_DNRD  = 5'd14;
  localparam logic [4:0] S_DNWR  = 5'd15;

  logic [4:0]    state, state_next;
  logic [CW-1:0] cnt, cnt_next;
  logic [CW-1:0] idx, idx_next;
  logic [CW-1:0] hit, hit_next;
  logic [CW-1:0] dstart, dstart_next;
  logic [1:0]    dcnt, dcnt_next;
  logic          nfree, nfree_next;
  logic [SW-1:0] size, size_next;
  logic [13:0]   faddr, faddr_next;
  logic [AW-1:0] nstart, nstart_next;
  hdr_t          hh, hh_next;
  logic [SW-1:0] rsize;
  logic [KW-1:0] need;

  assign rsize = SW'((KW'(req_size) + KW'(3)) & ~KW'(3));
  assign need  = KW'(size) + KW'(HEADER_BYTES);
  assign idle  = (state == S_IDLE);

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
      cnt   <= CW'(1);
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  // working payload registers
  always_ff @(posedge clk) begin
    idx    <= idx_next;
    hit    <= hit_next;
    dstart <= dstart_next;
    dcnt   <= dcnt_next;
    nfree  <= nfree_next;
    size   <= size_next;
    faddr  <= faddr_next;
    nstart <= nstart_next;
    hh     <= hh_next;
  end

  // sequence one request through the header RAM
  always_comb begin
    state_next  = state;
    cnt_next    = cnt;
    idx_next    = idx;
    hit_next    = hit;
    dstart_next = dstart;
    dcnt_next   = dcnt;
    nfree_next  = nfree;
    size_next   = size;
    faddr_next  = faddr;
    nstart_next = nstart;
    hh_next     = hh;
    mem         = '0;
    fin         = '0;
    unique case (state)
      S_INIT: begin
        mem.we          = 1'b1;
        mem.waddr       = '0;
        mem.wdata.used  = 1'b0;
        mem.wdata.start = '0;
        mem.wdata.len   = AW'(BUFFER_BYTES - HEADER_BYTES);
        state_next      = S_IDLE;
      end
      S_IDLE: begin
        if (accept) begin
          if (action == ACT_ALLOC) begin
            if (req_size == 16'd0 || 32'(req_size) > MAX_REQUEST) begin
              fin.valid  = 1'b1;
              fin.status = ST_AFAIL;
            end else begin
              size_next  = rsize;
              idx_next   = cnt - CW'(1);
              state_next = S_ARD;
            end
          end else begin
            faddr_next = block_addr;
            idx_next   = '0;
            state_next = S_FRD;
          end
        end
      end
      S_ARD: begin
        mem.re     = 1'b1;
        mem.raddr  = idx[IW-1:0];
        state_next = S_ACK;
      end
      S_ACK: begin
        if (!rdata.used && KW'(rdata.len) == KW'(size)) begin
          // exact fit: take the block whole
          mem.we          = 1'b1;
          mem.waddr       = idx[IW-1:0];
          mem.wdata       = rdata;
          mem.wdata.used  = 1'b1;
          fin.valid       = 1'b1;
          fin.addr        = 14'(KW'(rdata.start) + KW'(HEADER_BYTES));
          fin.status      = ST_OK;
          state_next      = S_IDLE;
        end else if (!rdata.used && KW'(rdata.len) > need) begin
          if (32'(cnt) >= HEAP_SLOTS) begin
            fin.valid  = 1'b1;
            fin.status = ST_AFAIL;
            state_next = S_IDLE;
          end else begin
            // split: shrink this block, carve the new one from its tail
            mem.we          = 1'b1;
            mem.waddr       = idx[IW-1:0];
            mem.wdata       = rdata;
            mem.wdata.len   = AW'(KW'(rdata.len) - need);
            nstart_next     = AW'(KW'(rdata.start) + KW'(rdata.len) - KW'(size));
            hit_next        = idx;
            if (cnt - CW'(1) > idx) begin
              idx_next   = cnt - CW'(1);
              state_next = S_UPRD;
            end else begin
              state_next = S_UPNEW;
            end
          end
        end else if (idx == '0) begin
          fin.valid  = 1'b1;
          fin.status = ST_AFAIL;
          state_next = S_IDLE;
        end else begin
          idx_next   = idx - CW'(1);
          state_next = S_ARD;
        end
      end
      S_UPRD: begin
        mem.re     = 1'b1;
        mem.raddr  = idx[IW-1:0];
        state_next = S_UPWR;
      end
      S_UPWR: begin
        // shift one entry up to open the slot after the split block
        mem.we    = 1'b1;
        mem.waddr = IW'(idx + CW'(1));
        mem.wdata = rdata;
        if (idx == hit + CW'(1)) begin
          state_next = S_UPNEW;
        end else begin
          idx_next   = idx - CW'(1);
          state_next = S_UPRD;
        end
      end
      S_UPNEW: begin
        mem.we          = 1'b1;
        mem.waddr       = IW'(hit + CW'(1));
        mem.wdata.used  = 1'b1;
        mem.wdata.len   = AW'(size);
        mem.wdata.start = nstart;
        cnt_next        = cnt + CW'(1);
        fin.valid       = 1'b1;
        fin.addr        = 14'(KW'(nstart) + KW'(HEADER_BYTES));
        fin.status      = ST_OK;
        state_next      = S_IDLE;
      end
      S_FRD: begin
        mem.re     = 1'b1;
        mem.raddr  = idx[IW-1:0];
        state_next = S_FCK;
      end
      S_FCK: begin
        if (KW'(rdata.start) + KW'(HEADER_BYTES) == KW'(faddr)) begin
          if (!rdata.used || rdata.len == '0) begin
            fin.valid  = 1'b1;
            fin.status = ST_FBAD;
            state_next = S_IDLE;
          end else begin
            hit_next      = idx;
            hh_next       = rdata;
            hh_next.used  = 1'b0;
            nfree_next    = 1'b0;
            state_next    = (idx + CW'(1) < cnt) ? S_NRD : S_PRE;
          end
        end else if (idx + CW'(1) == cnt) begin
          fin.valid  = 1'b1;
          fin.status = ST_FBAD;
          state_next = S_IDLE;
        end else begin
          idx_next   = idx + CW'(1);
          state_next = S_FRD;
        end
      end
      S_NRD: begin
        mem.re     = 1'b1;
        mem.raddr  = IW'(hit + CW'(1));
        state_next = S_NCK;
      end
      S_NCK: begin
        // absorb a free next block
        nfree_next = !rdata.used;
        if (!rdata.used) begin
          hh_next.len = AW'(KW'(hh.len) + KW'(HEADER_BYTES) + KW'(rdata.len));
        end
        state_next = S_PRE;
      end
      S_PRE: begin
        if (hit != '0) begin
          mem.re     = 1'b1;
          mem.raddr  = IW'(hit - CW'(1));
          state_next = S_PCK;
        end else begin
          mem.we      = 1'b1;
          mem.waddr   = hit[IW-1:0];
          mem.wdata   = hh;
          dstart_next = hit + CW'(1);
          dcnt_next   = {1'b0, nfree};
          state_next  = S_DEL;
        end
      end
      S_PCK: begin
        mem.we = 1'b1;
        if (!rdata.used) begin
          // fold into the free previous block
          mem.waddr     = IW'(hit - CW'(1));
          mem.wdata     = rdata;
          mem.wdata.len = AW'(KW'(rdata.len) + KW'(HEADER_BYTES) + KW'(hh.len));
          dstart_next   = hit;
          dcnt_next     = nfree ? 2'd2 : 2'd1;
        end else begin
          mem.waddr   = hit[IW-1:0];
          mem.wdata   = hh;
          dstart_next = hit + CW'(1);
          dcnt_next   = {1'b0, nfree};
        end
        state_next = S_DEL;
      end
      S_DEL: begin
        if (dcnt == 2'd0) begin
          fin.valid  = 1'b1;
          fin.status = ST_OK;
          state_next = S_IDLE;
        end else if (dstart + CW'(dcnt) < cnt) begin
          idx_next   = dstart + CW'(dcnt);
          state_next = S_DNRD;
        end else begin
          cnt_next   = cnt - CW'(dcnt);
          fin.valid  = 1'b1;
          fin.status = ST_OK;
          state_next = S_IDLE;
        end
      end
      S_DNRD: begin
        mem.re     = 1'b1;
        mem.raddr  = idx[IW-1:0];
        state_next = S_DNWR;
      end
      S_DNWR: begin
        // shift one entry down over the dropped slots
        mem.we    = 1'b1;
        mem.waddr = IW'(idx - CW'(dcnt));
        mem.wdata = rdata;
        if (idx + CW'(1) == cnt) begin
          cnt_next   = cnt - CW'(dcnt);
          fin.valid  = 1'b1;
          fin.status = ST_OK;
          state_next = S_IDLE;
        end else begin
          idx_next   = idx + CW'(1);
          state_next = S_DNRD;
        end
      end
      default: begin
        state_next = S_INIT;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    (cnt != '0) && (32'(cnt) <= HEAP_SLOTS))
    else $error("header count out of range");
  a_no_rw_clash: assert property (@(posedge clk) disable iff (rst)
    !(mem.we && mem.re && mem.waddr == mem.raddr))
    else $error("read and write hit the same header");
  a_fin_idle: assert property (@(posedge clk) disable iff (rst)
    fin.valid |=> (state == S_IDLE))
    else $error("result given while work continues");
  a_accept_idle: assert property (@(posedge clk) disable iff (rst)
    (accept && !idle) |-> 1'b0)
    else $error("request taken while busy");
`endif

endmodule

/* rtl/core/split_coalesce_heap_allocator.sv */
// Top level of the first-fit heap allocator: header RAM, sequencer, result register.
// Depends on scha_pkg, scha_ram, scha_ctrl.
//
//  channel  | handshake        | payload
//  request  | start / busy     | action, req_size, block_addr
//  result   | done (one cycle) | data_addr, status
//
// Allocate: headers are scanned one by one from the last block back; a split
// then shifts each header after the split block up one slot and writes the
// new header. Free: headers are scanned from the first block, the next and
// previous neighbors are checked, and headers are shifted down after a merge.
// A zero-size request is answered directly from idle, without a header RAM read.
// done is registered from the last step of the request and rises in the cycle after it.
// All cost comes from the single read port of the header RAM.
// After rst the block writes the initial free header before going idle.
// done cannot be stalled; each beat is held for exactly one cycle.
module split_coalesce_heap_allocator (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        action,
  input  logic [15:0] req_size,
  input  logic [13:0] block_addr,
  output logic        done,
  output logic [13:0] data_addr,
  output logic [1:0]  status
);
  import scha_pkg::*;

  mem_req_t mem;
  hdr_t     rdata;
  res_t     fin;
  logic     idle;
  logic     accept;

  assign busy   = !idle;
  assign accept = start && idle;

  scha_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .action     (action),
    .req_size   (req_size),
    .block_addr (block_addr),
    .rdata      (rdata),
    .mem        (mem),
    .fin        (fin),
    .idle       (idle)
  );

  scha_ram #(
    .WIDTH (HW),
    .DEPTH (HEAP_SLOTS)
  ) u_ram (
    .clk   (clk),
    .we    (mem.we),
    .waddr (mem.waddr),
    .wdata (mem.wdata),
    .re    (mem.re),
    .raddr (mem.raddr),
    .rdata (rdata)
  );

  // register the result beat
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= fin.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fin.valid) begin
      data_addr <= fin.addr;
      status    <= fin.status;
    end
  end

endmodule
